>>> sv/tile_fetch_address_unit_defines.svh
// ----------------------------------------------------------------------------
// tile_fetch_address_unit_defines.svh
// Assertion macros used by the tile fetch address unit checker (tfa_checker).
// ----------------------------------------------------------------------------
`ifndef TILE_FETCH_ADDRESS_UNIT_DEFINES_SVH
`define TILE_FETCH_ADDRESS_UNIT_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define TFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define TFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/tfa_pkg.sv
// ----------------------------------------------------------------------------
// tfa_pkg
// Types, codes and constants of the tile fetch address unit.
// ----------------------------------------------------------------------------
package tfa_pkg;

  // request codes
  localparam logic [1:0] REQ_TILE_INDEX = 2'd0;
  localparam logic [1:0] REQ_ROW_DATA   = 2'd1;
  localparam logic [1:0] REQ_FLIP       = 2'd2;

  // layer codes; code three behaves as a sprite
  localparam logic [1:0] LAYER_BG     = 2'd0;
  localparam logic [1:0] LAYER_WIN    = 2'd1;
  localparam logic [1:0] LAYER_SPRITE = 2'd2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_MAP_UPPER       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAP_UPPER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_TILE_DATA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TALL_SPRITES       = 3'd5;

  // address bases and byte constants
  localparam logic [15:0] MAP_BASE   = 16'h9800;
  localparam logic [15:0] DATA_BASE  = 16'h8000;
  localparam logic [7:0]  BYTE_ONES  = 8'hFF;
  localparam logic [7:0]  EVEN_MASK  = 8'hFE;
  localparam logic [7:0]  ODD_SET    = 8'h01;
  localparam logic [7:0]  WIN_STEP   = 8'd8;
  localparam int unsigned ATTR_YFLIP = 6;
  localparam int unsigned ATTR_XFLIP = 5;
  localparam int unsigned TILE_SIGN  = 7;

  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic       bg_map_upper;
    logic       win_map_upper;
    logic       unsigned_tile_data;
    logic       tall_sprites;
  } tfa_cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] layer;
    logic       plane;
    logic [7:0] pixel_x;
    logic [7:0] line;
    logic [7:0] win_x_counter;
    logic [7:0] win_line;
    logic [7:0] byte_in;
    logic [7:0] sprite_y;
    logic [7:0] sprite_attr;
    logic       bottom_half;
    logic       dma_active;
  } tfa_req_t;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  tile_out;
    logic [7:0]  attr_out;
    logic [7:0]  next_win_x;
  } tfa_result_t;

endpackage

>>> sv/tfa_if.sv
// ----------------------------------------------------------------------------
// tfa_if
// Request and result channels of the tile fetch address unit.
// ----------------------------------------------------------------------------
interface tfa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] layer;
  logic       plane;
  logic [7:0] pixel_x;
  logic [7:0] line;
  logic [7:0] win_x_counter;
  logic [7:0] win_line;
  logic [7:0] byte_in;
  logic [7:0] sprite_y;
  logic [7:0] sprite_attr;
  logic       bottom_half;
  logic       dma_active;

  modport source (
    output valid, req_type, layer, plane, pixel_x, line, win_x_counter,
           win_line, byte_in, sprite_y, sprite_attr, bottom_half, dma_active,
    input  ready
  );
  modport sink (
    input  valid, req_type, layer, plane, pixel_x, line, win_x_counter,
           win_line, byte_in, sprite_y, sprite_attr, bottom_half, dma_active,
    output ready
  );
endinterface

interface tfa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;
  logic [7:0]  tile_out;
  logic [7:0]  attr_out;
  logic [7:0]  next_win_x;

  modport source (
    output valid, address, tile_out, attr_out, next_win_x,
    input  ready
  );
  modport sink (
    input  valid, address, tile_out, attr_out, next_win_x,
    output ready
  );
endinterface

>>> sv/tfa_calc.sv
// ----------------------------------------------------------------------------
// tfa_calc
// Address, sprite tile/attribute and byte flip logic for one request.
// ----------------------------------------------------------------------------
module tfa_calc import tfa_pkg::*; (
  input  tfa_cfg_t    cfg,
  input  tfa_req_t    req,
  output tfa_result_t res
);

  logic       sprite;
  logic [7:0] bg_x;
  logic [7:0] bg_y;
  logic [7:0] spr_dy;
  logic [7:0] spr_tile;
  logic [7:0] spr_attr;
  logic       top_half;
  logic [2:0] row;
  logic       bit12;
  logic [7:0] flipped;

  assign sprite = req.layer[1];
  assign bg_x   = req.pixel_x + cfg.scroll_x;
  assign bg_y   = req.line + cfg.scroll_y;
  // +16 drops out of the low three bits
  assign spr_dy = req.line - req.sprite_y;

  assign spr_attr = req.dma_active ? BYTE_ONES : req.sprite_attr;
  // Y flip swaps which half the tile number's low bit selects
  assign top_half = req.bottom_half ^ ~spr_attr[ATTR_YFLIP];

  always_comb begin
    spr_tile = req.dma_active ? BYTE_ONES : req.byte_in;
    if (cfg.tall_sprites) begin
      spr_tile = top_half ? (spr_tile & EVEN_MASK) : (spr_tile | ODD_SET);
    end
  end

  always_comb begin
    bit12 = 1'b0;
    if (sprite) begin
      row = spr_dy[2:0] ^ {3{req.sprite_attr[ATTR_YFLIP]}};
    end else begin
      row   = (req.layer == LAYER_WIN) ? req.win_line[2:0] : bg_y[2:0];
      bit12 = ~(cfg.unsigned_tile_data | req.byte_in[TILE_SIGN]);
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      flipped[i] = req.byte_in[7-i];
    end
  end

  always_comb begin
    res            = '0;
    res.next_win_x = req.win_x_counter;
    case (req.req_type)
      REQ_TILE_INDEX: begin
        if (sprite) begin
          res.tile_out = spr_tile;
          res.attr_out = spr_attr;
        end else if (req.layer == LAYER_WIN) begin
          res.address    = MAP_BASE | {5'b0, cfg.win_map_upper,
                                       req.win_line[7:3], req.win_x_counter[7:3]};
          res.next_win_x = req.win_x_counter + WIN_STEP;
        end else begin
          res.address = MAP_BASE | {5'b0, cfg.bg_map_upper, bg_y[7:3], bg_x[7:3]};
        end
      end
      REQ_ROW_DATA: begin
        res.address = DATA_BASE | {3'b0, bit12, req.byte_in, row, req.plane};
      end
      REQ_FLIP: begin
        res.tile_out = (sprite && req.sprite_attr[ATTR_XFLIP]) ? flipped : req.byte_in;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/tile_fetch_address_unit.sv
// The result is registered and appears on out_chan in the cycle after the
// request transaction. 1 request per cycle unless out_chan stalls; the single
// result register reloads in the same cycle its content is taken.
// Reset (rst_n low, synchronous): result register empties, all configuration
// registers return to 0.
// ----------------------------------------------------------------------------
// tile_fetch_address_unit
// Tile map / tile data address generator for background, window and sprites.
// ----------------------------------------------------------------------------
module tile_fetch_address_unit import tfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tfa_in_if.sink                in_chan,
  tfa_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tfa_cfg_t    cfg_r;
  tfa_cfg_t    cfg_nxt;
  tfa_req_t    req;
  tfa_result_t res;
  tfa_result_t res_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        in_fire;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SCROLL_X:           cfg_nxt.scroll_x           = cfg_wdata;
        CFG_SCROLL_Y:           cfg_nxt.scroll_y           = cfg_wdata;
        CFG_BG_MAP_UPPER:       cfg_nxt.bg_map_upper       = cfg_wdata[0];
        CFG_WIN_MAP_UPPER:      cfg_nxt.win_map_upper      = cfg_wdata[0];
        CFG_UNSIGNED_TILE_DATA: cfg_nxt.unsigned_tile_data = cfg_wdata[0];
        CFG_TALL_SPRITES:       cfg_nxt.tall_sprites       = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign req = '{
    req_type:      in_chan.req_type,
    layer:         in_chan.layer,
    plane:         in_chan.plane,
    pixel_x:       in_chan.pixel_x,
    line:          in_chan.line,
    win_x_counter: in_chan.win_x_counter,
    win_line:      in_chan.win_line,
    byte_in:       in_chan.byte_in,
    sprite_y:      in_chan.sprite_y,
    sprite_attr:   in_chan.sprite_attr,
    bottom_half:   in_chan.bottom_half,
    dma_active:    in_chan.dma_active
  };

  tfa_calc u_calc (
    .cfg (cfg_r),
    .req (req),
    .res (res)
  );

  // accept while the result register is empty or being drained
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.address    = res_r.address;
  assign out_chan.tile_out   = res_r.tile_out;
  assign out_chan.attr_out   = res_r.attr_out;
  assign out_chan.next_win_x = res_r.next_win_x;

endmodule

>>> sv/tfa_checker.sv
// ----------------------------------------------------------------------------
// tfa_checker
// Port-level assertions for the tile fetch address unit, bound to the top.
// ----------------------------------------------------------------------------
`include "tile_fetch_address_unit_defines.svh"

module tfa_checker import tfa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic [1:0]  in_layer,
  input logic [7:0]  in_win_x_counter,
  input logic [7:0]  in_byte_in,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_address,
  input logic [7:0]  out_tile_out,
  input logic [7:0]  out_next_win_x
);

  logic in_fire;
  logic win_tile;
  logic bg_flip;

  assign in_fire  = in_valid && in_ready;
  assign win_tile = in_fire && (in_req_type == REQ_TILE_INDEX) && (in_layer == LAYER_WIN);
  assign bg_flip  = in_fire && (in_req_type == REQ_FLIP) && (in_layer == LAYER_BG);

  `TFA_ASSERT_NEXT(a_result_follows, clk, rst_n, in_fire, out_valid, "accepted request gave no result")
  `TFA_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "not ready with empty output")
  `TFA_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_address) && $stable(out_tile_out), "stalled result changed")
  `TFA_ASSERT_NEXT(a_win_advance, clk, rst_n, win_tile, out_next_win_x == $past(in_win_x_counter) + WIN_STEP, "window counter not advanced by 8")
  `TFA_ASSERT_NEXT(a_bg_flip_pass, clk, rst_n, bg_flip, (out_tile_out == $past(in_byte_in)) && (out_address == 16'h0000), "background flip altered byte")

endmodule

bind tile_fetch_address_unit tfa_checker u_tfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_req_type      (in_chan.req_type),
  .in_layer         (in_chan.layer),
  .in_win_x_counter (in_chan.win_x_counter),
  .in_byte_in       (in_chan.byte_in),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_address      (out_chan.address),
  .out_tile_out     (out_chan.tile_out),
  .out_next_win_x   (out_chan.next_win_x)
);

>>> sim/tile_fetch_address_checker.sv
// ----------------------------------------------------------------------------
// tile_fetch_address_checker
// Watches the request, result and register ports of the tile fetch address
// unit, predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------
module tile_fetch_address_checker import tfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tfa_in_if                     in_mon,
  tfa_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           pending,
  output int unsigned           checked
);

  localparam logic [7:0] SPRITE_Y_OFFSET = 8'd16;

  tfa_cfg_t    regs;
  tfa_result_t expected_results[$];
  int unsigned n_fail;
  int unsigned n_checked;

  function automatic logic [7:0] reverse_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = b[i];
    return r;
  endfunction

  function automatic tfa_result_t predict_fetch(input tfa_req_t r, input tfa_cfg_t c);
    tfa_result_t res;
    logic        sprite;
    logic        take_even;
    logic        hi_bank;
    logic [7:0]  t;
    logic [7:0]  a;
    logic [7:0]  sum_x;
    logic [7:0]  sum_y;
    logic [7:0]  sprite_dy;
    logic [2:0]  row;
    res = '0;
    res.next_win_x = r.win_x_counter;
    sprite = r.layer[1];  // layer code three also counts as a sprite
    case (r.req_type)
      REQ_TILE_INDEX: begin
        if (sprite) begin
          t = r.dma_active ? BYTE_ONES : r.byte_in;
          a = r.dma_active ? BYTE_ONES : r.sprite_attr;
          if (c.tall_sprites) begin
            // Y flip swaps which half gets the even tile
            take_even = a[ATTR_YFLIP] ? r.bottom_half : !r.bottom_half;
            t = take_even ? (t & EVEN_MASK) : (t | ODD_SET);
          end
          res.tile_out = t;
          res.attr_out = a;
        end else if (r.layer == LAYER_WIN) begin
          res.address = MAP_BASE | {5'd0, c.win_map_upper, r.win_line[7:3],
                                    r.win_x_counter[7:3]};
          res.next_win_x = r.win_x_counter + WIN_STEP;
        end else begin
          sum_x = r.pixel_x + c.scroll_x;
          sum_y = r.line + c.scroll_y;
          res.address = MAP_BASE | {5'd0, c.bg_map_upper, sum_y[7:3], sum_x[7:3]};
        end
      end
      REQ_ROW_DATA: begin
        hi_bank = 1'b0;
        if (sprite) begin
          sprite_dy = r.line + SPRITE_Y_OFFSET - r.sprite_y;
          row = r.sprite_attr[ATTR_YFLIP] ? ~sprite_dy[2:0] : sprite_dy[2:0];
        end else begin
          sum_y = r.line + c.scroll_y;
          row = (r.layer == LAYER_WIN) ? r.win_line[2:0] : sum_y[2:0];
          // signed mode: tiles 0..127 live in the upper bank
          hi_bank = !(c.unsigned_tile_data || r.byte_in[TILE_SIGN]);
        end
        res.address = DATA_BASE | {3'd0, hi_bank, r.byte_in, row, r.plane};
      end
      REQ_FLIP: begin
        res.tile_out = (sprite && r.sprite_attr[ATTR_XFLIP]) ?
                       reverse_byte(r.byte_in) : r.byte_in;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      n_fail++;
      if (n_fail <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tfa_req_t    req;
    tfa_result_t got;
    tfa_result_t want;
    if (!rst_n) begin
      regs = '0;
      expected_results.delete();
    end else begin
      // results leaving this edge belong to earlier requests
      if (out_mon.valid && out_mon.ready) begin
        got.address    = out_mon.address;
        got.tile_out   = out_mon.tile_out;
        got.attr_out   = out_mon.attr_out;
        got.next_win_x = out_mon.next_win_x;
        if (expected_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result transaction with nothing outstanding: %h",
                     $realtime, got);
        end else begin
          want = expected_results.pop_front();
          check_field("address", want.address, got.address);
          check_field("tile_out", want.tile_out, got.tile_out);
          check_field("attr_out", want.attr_out, got.attr_out);
          check_field("next_win_x", want.next_win_x, got.next_win_x);
          n_checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req.req_type      = in_mon.req_type;
        req.layer         = in_mon.layer;
        req.plane         = in_mon.plane;
        req.pixel_x       = in_mon.pixel_x;
        req.line          = in_mon.line;
        req.win_x_counter = in_mon.win_x_counter;
        req.win_line      = in_mon.win_line;
        req.byte_in       = in_mon.byte_in;
        req.sprite_y      = in_mon.sprite_y;
        req.sprite_attr   = in_mon.sprite_attr;
        req.bottom_half   = in_mon.bottom_half;
        req.dma_active    = in_mon.dma_active;
        expected_results.push_back(predict_fetch(req, regs));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCROLL_X:           regs.scroll_x           = cfg_wdata;
          CFG_SCROLL_Y:           regs.scroll_y           = cfg_wdata;
          CFG_BG_MAP_UPPER:       regs.bg_map_upper       = cfg_wdata[0];
          CFG_WIN_MAP_UPPER:      regs.win_map_upper      = cfg_wdata[0];
          CFG_UNSIGNED_TILE_DATA: regs.unsigned_tile_data = cfg_wdata[0];
          CFG_TALL_SPRITES:       regs.tall_sprites       = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    mismatches <= n_fail;
    pending    <= expected_results.size();
    checked    <= n_checked;
  end

endmodule

>>> sim/tile_fetch_address_unit_tb.sv
// ----------------------------------------------------------------------------
// tile_fetch_address_unit_tb
// Directed corner requests, then random requests under several register
// settings, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tile_fetch_address_unit_tb;
  import tfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned ITEMS_PER_PHASE  = 305;
  localparam int unsigned IDLE_PCT         = 32;
  localparam logic [1:0]  REQ_IGNORED      = 2'd3;
  localparam logic [1:0]  LAYER_ALT_SPRITE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic        hold_off;
  logic        steady;
  int unsigned cyc;
  int unsigned n_settings;
  int unsigned sent_by_req [4];
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  tfa_in_if  in_chan ();
  tfa_out_if out_chan ();

  tile_fetch_address_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  tile_fetch_address_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tile_fetch_address_unit regression: fail");
      $finish;
    end
  end

  // long output stall first, later a stretch with no idling on either side
  initial begin
    hold_off = 1'b0;
    steady = 1'b0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (250) @(posedge clk);
    hold_off <= 1'b0;
    repeat (600) @(posedge clk);
    steady <= 1'b1;
    repeat (700) @(posedge clk);
    steady <= 1'b0;
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off)
        out_chan.ready <= 1'b0;
      else if (steady)
        out_chan.ready <= 1'b1;
      else
        out_chan.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic tfa_req_t random_req();
    tfa_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.req_type = (pick < 35) ? REQ_TILE_INDEX : (pick < 70) ? REQ_ROW_DATA :
                 (pick < 96) ? REQ_FLIP : REQ_IGNORED;
    pick = $urandom_range(0, 99);
    r.layer = (pick < 30) ? LAYER_BG : (pick < 60) ? LAYER_WIN :
              (pick < 96) ? LAYER_SPRITE : LAYER_ALT_SPRITE;
    r.plane         = 1'($urandom_range(0, 1));
    r.pixel_x       = 8'($urandom_range(0, 255));
    r.line          = 8'($urandom_range(0, 153));
    r.win_x_counter = 8'($urandom_range(0, 255));
    r.win_line      = 8'($urandom_range(0, 255));
    r.byte_in       = 8'($urandom_range(0, 255));
    r.sprite_y      = 8'($urandom_range(0, 255));
    r.sprite_attr   = 8'($urandom_range(0, 255));
    r.bottom_half   = 1'($urandom_range(0, 1));
    r.dma_active    = ($urandom_range(0, 99) < 15);
    return r;
  endfunction

  function automatic tfa_cfg_t random_setting();
    tfa_cfg_t c;
    c.scroll_x           = 8'($urandom_range(0, 255));
    c.scroll_y           = 8'($urandom_range(0, 255));
    c.bg_map_upper       = 1'($urandom_range(0, 1));
    c.win_map_upper      = 1'($urandom_range(0, 1));
    c.unsigned_tile_data = 1'($urandom_range(0, 1));
    c.tall_sprites       = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic push_req(input tfa_req_t r);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.req_type      <= r.req_type;
    in_chan.layer         <= r.layer;
    in_chan.plane         <= r.plane;
    in_chan.pixel_x       <= r.pixel_x;
    in_chan.line          <= r.line;
    in_chan.win_x_counter <= r.win_x_counter;
    in_chan.win_line      <= r.win_line;
    in_chan.byte_in       <= r.byte_in;
    in_chan.sprite_y      <= r.sprite_y;
    in_chan.sprite_attr   <= r.sprite_attr;
    in_chan.bottom_half   <= r.bottom_half;
    in_chan.dma_active    <= r.dma_active;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_by_req[r.req_type]++;
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic apply_setting(input tfa_cfg_t c);
    wait_drained();
    write_reg(CFG_SCROLL_X, c.scroll_x);
    write_reg(CFG_SCROLL_Y, c.scroll_y);
    write_reg(CFG_BG_MAP_UPPER, {7'd0, c.bg_map_upper});
    write_reg(CFG_WIN_MAP_UPPER, {7'd0, c.win_map_upper});
    write_reg(CFG_UNSIGNED_TILE_DATA, {7'd0, c.unsigned_tile_data});
    write_reg(CFG_TALL_SPRITES, {7'd0, c.tall_sprites});
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    tfa_req_t r;
    tfa_cfg_t s;
    in_chan.valid         = 1'b0;
    in_chan.req_type      = REQ_TILE_INDEX;
    in_chan.layer         = LAYER_BG;
    in_chan.plane         = 1'b0;
    in_chan.pixel_x       = '0;
    in_chan.line          = '0;
    in_chan.win_x_counter = '0;
    in_chan.win_line      = '0;
    in_chan.byte_in       = '0;
    in_chan.sprite_y      = '0;
    in_chan.sprite_attr   = '0;
    in_chan.bottom_half   = 1'b0;
    in_chan.dma_active    = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_SCROLL_X;
    cfg_wdata             = '0;
    n_settings            = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: no scroll, lower maps, signed tiles, 8x8 sprites
    r = random_req(); r.req_type = REQ_TILE_INDEX; r.layer = LAYER_BG;
    r.pixel_x = 8'd0; r.line = 8'd0; push_req(r);
    r.pixel_x = 8'd255; r.line = 8'd153; push_req(r);
    r = random_req(); r.req_type = REQ_TILE_INDEX; r.layer = LAYER_WIN;
    r.win_x_counter = 8'd248; r.win_line = 8'd255; push_req(r);  // column wraps
    r.win_x_counter = 8'd7; r.win_line = 8'd0; push_req(r);
    r = random_req(); r.req_type = REQ_TILE_INDEX; r.layer = LAYER_SPRITE;
    r.byte_in = 8'h5A; r.sprite_attr = 8'h40; r.dma_active = 1'b0; push_req(r);
    r.dma_active = 1'b1; push_req(r);
    r = random_req(); r.req_type = REQ_ROW_DATA; r.layer = LAYER_BG;
    r.byte_in = 8'h7F; r.plane = 1'b0; r.line = 8'd153; push_req(r);
    r.byte_in = 8'h80; r.plane = 1'b1; push_req(r);
    r.layer = LAYER_WIN; r.win_line = 8'd255; r.byte_in = 8'h00; push_req(r);
    r = random_req(); r.req_type = REQ_ROW_DATA; r.layer = LAYER_SPRITE;
    r.line = 8'd0; r.sprite_y = 8'd255; r.sprite_attr = 8'h40; push_req(r);
    r.line = 8'd153; r.sprite_y = 8'd0; r.sprite_attr = 8'h00; push_req(r);
    r = random_req(); r.req_type = REQ_FLIP; r.layer = LAYER_SPRITE;
    r.sprite_attr = 8'h20; r.byte_in = 8'h01; push_req(r);
    r.layer = LAYER_BG; push_req(r);  // non-sprite flip passes the byte
    r.layer = LAYER_SPRITE; r.sprite_attr = 8'hDF; r.byte_in = 8'hC3; push_req(r);
    r = random_req(); r.req_type = REQ_TILE_INDEX; r.layer = LAYER_ALT_SPRITE;
    r.dma_active = 1'b0; push_req(r);
    r = random_req(); r.req_type = REQ_IGNORED; push_req(r);

    s = '1;
    apply_setting(s);
    r = random_req(); r.req_type = REQ_TILE_INDEX; r.layer = LAYER_BG;
    r.pixel_x = 8'd255; r.line = 8'd153; push_req(r);
    r.layer = LAYER_WIN; r.win_x_counter = 8'd255; r.win_line = 8'd255; push_req(r);
    // tall sprite halves, with and without Y flip
    for (int k = 0; k < 4; k++) begin
      r = random_req(); r.req_type = REQ_TILE_INDEX; r.layer = LAYER_SPRITE;
      r.dma_active = 1'b0; r.bottom_half = k[0];
      r.sprite_attr = k[1] ? 8'h40 : 8'h00;
      push_req(r);
    end
    r.dma_active = 1'b1; r.bottom_half = 1'b0; push_req(r);
    r = random_req(); r.req_type = REQ_ROW_DATA; r.layer = LAYER_BG;
    r.byte_in = 8'h00; push_req(r);
    r = random_req(); r.req_type = REQ_FLIP; r.layer = LAYER_ALT_SPRITE;
    r.sprite_attr = 8'h20; push_req(r);

    for (int phase = 0; phase < PHASES; phase++) begin
      s = random_setting();
      if (phase == 0) s = '0;
      if (phase == 1) s = '1;
      apply_setting(s);
      repeat (ITEMS_PER_PHASE) push_req(random_req());
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("sent %0d tile index, %0d row data, %0d flip and %0d ignored requests",
             sent_by_req[REQ_TILE_INDEX], sent_by_req[REQ_ROW_DATA],
             sent_by_req[REQ_FLIP], sent_by_req[REQ_IGNORED]);
    $display("%0d results compared over %0d register settings, one long output stall",
             checked, n_settings);
    if (mismatches == 0 && pending == 0)
      $display("tile_fetch_address_unit regression: pass");
    else
      $display("tile_fetch_address_unit regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/tfa_pkg.sv
sv/tfa_if.sv
sv/tfa_calc.sv
sv/tile_fetch_address_unit.sv
sv/tfa_checker.sv
sim/tile_fetch_address_checker.sv
sim/tile_fetch_address_unit_tb.sv
